// ----- rtl/l3bw_pkg.sv -----
// shared types and constants for the three-wire control bus byte writer
`default_nettype none

package l3bw_pkg;

  // bits shifted out for each byte
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);

  // input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_ADDR = 1'b1;

  // sequencer phases: idle, and one per kind of pin segment
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HALT  = 3'd1,
    PH_SETUP = 3'd2,
    PH_BITLO = 3'd3,
    PH_BITHI = 3'd4,
    PH_END   = 3'd5
  } phase_t;

  // classified byte command handed from the front to the sequencer
  typedef struct packed {
    logic       mode;   // mode pin level through setup and bits
    logic       halt;   // send a halt segment before setup
    logic [7:0] data;   // byte, lsb first
  } cmd_t;

  // one pin segment
  typedef struct packed {
    logic clock;
    logic data;
    logic mode;
    logic last;
  } seg_t;

  // valid/ready pair between internal stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

// ----- rtl/l3bw_front.sv -----
// front end: accepts byte commands, classifies them and queues them
`default_nettype none

module l3bw_front
  import l3bw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       opcode,
  input  wire logic       halt_first,
  input  wire logic [7:0] payload_byte,
  output hs_t             cmd_hs_out,   // valid driven here
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_xfer;
  logic       pop_xfer;
  cmd_t       classified;

  // classify: address writes run in mode low and never halt
  always_comb begin
    classified.mode = (opcode == OP_DATA);
    classified.halt = (opcode == OP_DATA) && halt_first;
    classified.data = payload_byte;
  end

  assign full      = (count == 2'd2);
  assign push_xfer = push && !full;
  assign pop_xfer  = (count != 2'd0) && cmd_ready;

  assign cmd_hs_out.valid = (count != 2'd0);
  assign cmd_hs_out.ready = cmd_ready;
  assign cmd              = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_xfer) begin
      entries[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_xfer) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_xfer) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_xfer && !pop_xfer) begin
        count <= count + 2'd1;
      end else if (!push_xfer && pop_xfer) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/l3bw_seq.sv -----
// back end: segment sequencer with a hold timer per segment
`default_nettype none

module l3bw_seq
  import l3bw_pkg::*;
#(
  parameter int unsigned SEGMENT_TICKS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire hs_t  cmd_hs_in,   // valid used here
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      seg_valid,
  input  wire logic seg_ready,
  output seg_t      seg
);

  localparam int unsigned TICK_W = (SEGMENT_TICKS > 1) ? $clog2(SEGMENT_TICKS) : 1;
  localparam logic [TICK_W-1:0] TICK_RELOAD = TICK_W'(SEGMENT_TICKS - 1);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

  phase_t               state;
  phase_t               state_next;
  logic [7:0]           shift_reg;
  logic [BIT_IDX_W-1:0] bit_count;
  logic                 mode;
  logic [TICK_W-1:0]    tick;
  logic                 seg_xfer;
  logic                 cmd_take;

  assign seg_xfer = seg_valid && seg_ready;
  assign cmd_take = cmd_hs_in.valid && cmd_ready;

  // next phase
  always_comb begin
    state_next = state;
    unique case (state)
      PH_IDLE: begin
        if (cmd_hs_in.valid) begin
          state_next = cmd.halt ? PH_HALT : PH_SETUP;
        end
      end
      PH_HALT: begin
        if (seg_xfer) state_next = PH_SETUP;
      end
      PH_SETUP: begin
        if (seg_xfer) state_next = PH_BITLO;
      end
      PH_BITLO: begin
        if (seg_xfer) state_next = PH_BITHI;
      end
      PH_BITHI: begin
        if (seg_xfer) state_next = (bit_count == LAST_BIT) ? PH_END : PH_BITLO;
      end
      PH_END: begin
        if (seg_xfer) state_next = PH_IDLE;
      end
      default: state_next = PH_IDLE;
    endcase
  end

  // segment outputs per phase
  always_comb begin
    cmd_ready = 1'b0;
    seg_valid = 1'b0;
    seg       = '{clock: 1'b1, data: 1'b0, mode: 1'b1, last: 1'b0};
    unique case (state)
      PH_IDLE: begin
        cmd_ready = 1'b1;
      end
      PH_HALT: begin
        seg_valid = (tick == '0);
        seg       = '{clock: 1'b1, data: 1'b0, mode: 1'b0, last: 1'b0};
      end
      PH_SETUP: begin
        seg_valid = (tick == '0);
        seg       = '{clock: 1'b1, data: 1'b0, mode: mode, last: 1'b0};
      end
      PH_BITLO: begin
        seg_valid = (tick == '0);
        seg       = '{clock: 1'b0, data: shift_reg[0], mode: mode, last: 1'b0};
      end
      PH_BITHI: begin
        seg_valid = (tick == '0);
        seg       = '{clock: 1'b1, data: shift_reg[0], mode: mode, last: 1'b0};
      end
      PH_END: begin
        seg_valid = (tick == '0);
        seg       = '{clock: 1'b1, data: 1'b0, mode: 1'b1, last: 1'b1};
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // control registers and hold timer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      bit_count <= '0;
      tick      <= '0;
    end else begin
      state <= state_next;
      if (cmd_take) begin
        bit_count <= '0;
      end else if (seg_xfer && state == PH_BITHI) begin
        bit_count <= bit_count + 1'b1;
      end
      if (seg_xfer) begin
        tick <= TICK_RELOAD;
      end else if (tick != '0) begin
        tick <= tick - 1'b1;
      end
    end
  end

  // byte and mode of the command in flight
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      shift_reg <= cmd.data;
      mode      <= cmd.mode;
    end else if (seg_xfer && state == PH_BITHI) begin
      shift_reg <= {1'b0, shift_reg[7:1]};
    end
  end

  // a nonzero bit count only lives inside the bit phases
  a_bit_count_phase: assert property (@(posedge clk) disable iff (rst)
    (bit_count != '0) |-> (state == PH_BITLO || state == PH_BITHI))
    else $error("bit count set outside bit phases");

  // the closing segment always returns the sequencer to idle
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (seg_xfer && state == PH_END) |=> (state == PH_IDLE))
    else $error("sequencer did not return to idle after closing segment");

  // every segment transfer restarts the hold timer
  a_tick_reload: assert property (@(posedge clk) disable iff (rst)
    seg_xfer |=> (tick == TICK_RELOAD))
    else $error("hold timer not reloaded after segment");

  // halt segments only precede data writes
  a_halt_mode: assert property (@(posedge clk) disable iff (rst)
    (state == PH_HALT) |-> mode)
    else $error("halt phase on an address write");

endmodule

`default_nettype wire

// ----- rtl/l3bw_outq.sv -----
// result queue: two-entry buffer of pin segments toward the receiver
`default_nettype none

module l3bw_outq
  import l3bw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic seg_valid,
  output logic      seg_ready,
  input  wire seg_t seg,
  output logic      empty,
  input  wire logic pop,
  output seg_t      head
);

  seg_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_xfer;
  logic       rd_xfer;

  assign seg_ready = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign wr_xfer   = seg_valid && seg_ready;
  assign rd_xfer   = pop && !empty;
  assign head      = entries[rd_ptr];

  // segment storage
  always_ff @(posedge clk) begin
    if (wr_xfer) begin
      entries[wr_ptr] <= seg;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_xfer) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_xfer) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_xfer && !rd_xfer) begin
        count <= count + 2'd1;
      end else if (!wr_xfer && rd_xfer) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/l3_bus_byte_writer.sv -----
// top level of the three-wire control bus byte writer
//
// Usage: byte commands go in through a queue-style port (push/full) with
// opcode, halt_first and payload_byte; a transfer happens when push is high
// and full is low. Each byte turns into 18 pin segments (address write, or
// data write without halt) or 19 (data write with halt), read out through a
// second queue-style port (empty/pop) carrying l3_clock, l3_data, l3_mode and
// last_segment, which marks the closing idle segment of the byte.
// When the sequencer is free and its hold timer has run out, the first
// segment of a byte passes from the command queue through the sequencer
// state register into the result queue. The spacing of segments is set by
// the segment hold timer in the sequencer (SEGMENT_TICKS), which restarts on
// every segment transfer. Two commands queue ahead of the sequencer, so new
// bytes are taken while one is being sent.
// Reset (rst, synchronous) empties both queues and returns the sequencer to
// idle. When the receiver stops popping, the two-entry result queue fills,
// the sequencer waits on the current segment, and the command queue backs up
// until full rises; nothing is dropped.
`default_nettype none

module l3_bus_byte_writer
  import l3bw_pkg::*;
#(
  parameter int unsigned SEGMENT_TICKS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       opcode,
  input  wire logic       halt_first,
  input  wire logic [7:0] payload_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic            l3_clock,
  output logic            l3_data,
  output logic            l3_mode,
  output logic            last_segment
);

  hs_t  cmd_hs;
  logic cmd_ready;
  cmd_t cmd;
  logic seg_valid;
  logic seg_ready;
  seg_t seg;
  seg_t head;

  // front: accept and classify byte commands
  l3bw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .halt_first   (halt_first),
    .payload_byte (payload_byte),
    .cmd_hs_out   (cmd_hs),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // back: segment sequencer
  l3bw_seq #(
    .SEGMENT_TICKS (SEGMENT_TICKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_hs_in (cmd_hs),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  // result queue toward the receiver
  l3bw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign l3_clock     = head.clock;
  assign l3_data      = head.data;
  assign l3_mode      = head.mode;
  assign last_segment = head.last;

endmodule

`default_nettype wire
